// ===== rtl/core/fcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrd_pkg
// Shared types and codes for the FastCGI record deframer: record type codes,
// route, byte role and end-action codes, per-byte state and result bundles.
// ----------------------------------------------------------------------------
package fcrd_pkg;

  localparam int unsigned HdrLen = 8;
  localparam int unsigned CountW = 17;

  // record type codes from the header type byte
  localparam logic [7:0] TypeBegin     = 8'd1;
  localparam logic [7:0] TypeAbort     = 8'd2;
  localparam logic [7:0] TypeParams    = 8'd4;
  localparam logic [7:0] TypeStdin     = 8'd5;
  localparam logic [7:0] TypeData      = 8'd8;
  localparam logic [7:0] TypeGetValues = 8'd9;

  // begin-request content length that is accepted
  localparam logic [15:0] BeginLen = 16'd8;

  // byte role codes
  localparam logic [1:0] RoleHeader  = 2'd0;
  localparam logic [1:0] RoleContent = 2'd1;
  localparam logic [1:0] RolePadding = 2'd2;

  // content route codes
  localparam logic [2:0] RouteDiscard = 3'd0;
  localparam logic [2:0] RouteLocal   = 3'd1;
  localparam logic [2:0] RouteParams  = 3'd2;
  localparam logic [2:0] RouteStdin   = 3'd3;
  localparam logic [2:0] RouteData    = 3'd4;

  // end action codes
  localparam logic [2:0] ActNone      = 3'd0;
  localparam logic [2:0] ActIgnored   = 3'd1;
  localparam logic [2:0] ActGetValues = 3'd2;
  localparam logic [2:0] ActUnknownMg = 3'd3;
  localparam logic [2:0] ActBegin     = 3'd4;
  localparam logic [2:0] ActAbort     = 3'd5;
  localparam logic [2:0] ActStreamEnd = 3'd6;

  // header byte positions
  localparam logic [2:0] PosType   = 3'd1;
  localparam logic [2:0] PosIdHi   = 3'd2;
  localparam logic [2:0] PosIdLo   = 3'd3;
  localparam logic [2:0] PosLenHi  = 3'd4;
  localparam logic [2:0] PosLenLo  = 3'd5;
  localparam logic [2:0] PosPadLen = 3'd6;
  localparam logic [2:0] PosLast   = 3'd7;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [7:0]        rec_type;
    logic [15:0]       req_id;
    logic [15:0]       content_len;
    logic [7:0]        pad_len;
    logic              invalid;
    logic [15:0]       role_word;
    logic              keep;
  } rec_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  byte_role;
    logic [2:0]  route;
    logic        header_done;
    logic [7:0]  record_type;
    logic [15:0] record_id;
    logic [15:0] content_length;
    logic        record_valid;
    logic        record_end;
    logic [2:0]  end_action;
    logic [15:0] begin_role;
    logic        keep_connection;
  } byte_result_t;

endpackage

// ===== rtl/core/fcrd_step.sv =====
// ----------------------------------------------------------------------------
// fcrd_step
// Per-byte record logic: header capture, content/padding counting, checks,
// routing and end action, from the current record state and one byte.
// ----------------------------------------------------------------------------
module fcrd_step (
  input  fcrd_pkg::rec_state_t   state_q,
  input  logic [7:0]             rx_byte,
  output fcrd_pkg::rec_state_t   state_next,
  output fcrd_pkg::byte_result_t res
);

  localparam logic [fcrd_pkg::CountW-1:0] HdrLenC = fcrd_pkg::CountW'(fcrd_pkg::HdrLen);

  fcrd_pkg::rec_state_t nx;
  logic [fcrd_pkg::CountW-1:0] cnt_inc;
  logic [fcrd_pkg::CountW-1:0] content_end;
  logic [fcrd_pkg::CountW-1:0] record_len;
  logic in_header;
  logic in_content;
  logic hdone;
  logic rend;
  logic [1:0] role;
  logic [2:0] route;
  logic [2:0] action;

  function automatic logic check_invalid(input fcrd_pkg::rec_state_t s);
    logic bad;
    bad = 1'b0;
    if (s.req_id == 16'd0) begin
      bad = 1'b0;
    end else if (s.rec_type == fcrd_pkg::TypeBegin) begin
      bad = (s.content_len != fcrd_pkg::BeginLen);
    end else if (s.rec_type == fcrd_pkg::TypeAbort) begin
      bad = (s.content_len != 16'd0);
    end else begin
      bad = !(s.rec_type == fcrd_pkg::TypeParams || s.rec_type == fcrd_pkg::TypeStdin ||
              s.rec_type == fcrd_pkg::TypeData);
    end
    return bad;
  endfunction

  function automatic logic [2:0] content_route(input fcrd_pkg::rec_state_t s);
    logic [2:0] r;
    priority if (s.invalid) begin
      r = fcrd_pkg::RouteDiscard;
    end else if (s.req_id == 16'd0 || s.rec_type == fcrd_pkg::TypeBegin ||
                 s.rec_type == fcrd_pkg::TypeAbort) begin
      r = fcrd_pkg::RouteLocal;
    end else if (s.rec_type == fcrd_pkg::TypeParams) begin
      r = fcrd_pkg::RouteParams;
    end else if (s.rec_type == fcrd_pkg::TypeStdin) begin
      r = fcrd_pkg::RouteStdin;
    end else begin
      r = fcrd_pkg::RouteData;
    end
    return r;
  endfunction

  function automatic logic [2:0] end_code(input fcrd_pkg::rec_state_t s);
    logic [2:0] a;
    priority if (s.req_id == 16'd0) begin
      a = (s.rec_type == fcrd_pkg::TypeGetValues) ? fcrd_pkg::ActGetValues
                                                  : fcrd_pkg::ActUnknownMg;
    end else if (s.invalid) begin
      a = fcrd_pkg::ActIgnored;
    end else if (s.rec_type == fcrd_pkg::TypeBegin) begin
      a = fcrd_pkg::ActBegin;
    end else if (s.rec_type == fcrd_pkg::TypeAbort) begin
      a = fcrd_pkg::ActAbort;
    end else begin
      a = (s.content_len == 16'd0) ? fcrd_pkg::ActStreamEnd : fcrd_pkg::ActNone;
    end
    return a;
  endfunction

  assign in_header   = (state_q.byte_count[fcrd_pkg::CountW-1:3] == '0);
  assign content_end = HdrLenC + fcrd_pkg::CountW'(state_q.content_len);
  assign in_content  = !in_header && (state_q.byte_count < content_end);
  assign cnt_inc     = state_q.byte_count + 1'b1;

  always_comb begin
    nx    = state_q;
    hdone = 1'b0;
    role  = fcrd_pkg::RoleHeader;
    route = fcrd_pkg::RouteDiscard;
    if (in_header) begin
      unique case (state_q.byte_count[2:0])
        fcrd_pkg::PosType:   nx.rec_type          = rx_byte;
        fcrd_pkg::PosIdHi:   nx.req_id[15:8]      = rx_byte;
        fcrd_pkg::PosIdLo:   nx.req_id[7:0]       = rx_byte;
        fcrd_pkg::PosLenHi:  nx.content_len[15:8] = rx_byte;
        fcrd_pkg::PosLenLo:  nx.content_len[7:0]  = rx_byte;
        fcrd_pkg::PosPadLen: nx.pad_len           = rx_byte;
        default: ;
      endcase
      if (state_q.byte_count[2:0] == fcrd_pkg::PosLast) begin
        hdone      = 1'b1;
        nx.invalid = check_invalid(nx);
      end
    end else if (in_content) begin
      role  = fcrd_pkg::RoleContent;
      route = content_route(state_q);
      // role and flags from the first three begin-request content bytes
      if (!state_q.invalid && state_q.req_id != 16'd0 &&
          state_q.rec_type == fcrd_pkg::TypeBegin) begin
        if (state_q.byte_count == HdrLenC) begin
          nx.role_word[15:8] = rx_byte;
        end else if (state_q.byte_count == HdrLenC + 1'b1) begin
          nx.role_word[7:0] = rx_byte;
        end else if (state_q.byte_count == HdrLenC + 2'd2) begin
          nx.keep = rx_byte[0];
        end
      end
    end else begin
      role = fcrd_pkg::RolePadding;
    end
    nx.byte_count = cnt_inc;
  end

  assign record_len = HdrLenC + fcrd_pkg::CountW'(nx.content_len) +
                      fcrd_pkg::CountW'(nx.pad_len);
  assign rend       = (cnt_inc >= HdrLenC) && (cnt_inc >= record_len);
  assign action     = rend ? end_code(nx) : fcrd_pkg::ActNone;

  always_comb begin
    res.data_byte       = rx_byte;
    res.byte_role       = role;
    res.route           = route;
    res.header_done     = hdone;
    res.record_type     = nx.rec_type;
    res.record_id       = nx.req_id;
    res.content_length  = nx.content_len;
    res.record_valid    = (cnt_inc >= HdrLenC) && !nx.invalid;
    res.record_end      = rend;
    res.end_action      = action;
    res.begin_role      = (action == fcrd_pkg::ActBegin) ? nx.role_word : 16'd0;
    res.keep_connection = (action == fcrd_pkg::ActBegin) ? nx.keep : 1'b0;
  end

  // record state is dropped once the last byte has gone
  assign state_next = rend ? '0 : nx;

endmodule

// ===== rtl/core/fastcgi_record_deframer.sv =====
// ----------------------------------------------------------------------------
// fastcgi_record_deframer
// Splits one connection's byte stream into FastCGI records: header capture,
// local header checks, content routing and an action code at record end.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | sink      | in_valid / in_stall    | rx_byte
//   out     | source    | out_valid / out_stall  | data_byte .. keep_connection
//
// one request per cycle sustained while out_stall is low; each byte produces exactly one result
// path: input register, then the record logic into the result register;
// record state advances as the byte leaves the input register
// rst is synchronous, active high, and clears the pipeline valids and record state
// a stall on the output holds the result register and backs up into in_stall
// in the same cycle, so no request is dropped or repeated
// ----------------------------------------------------------------------------
module fastcgi_record_deframer (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [1:0]  byte_role,
  output logic [2:0]  route,
  output logic        header_done,
  output logic [7:0]  record_type,
  output logic [15:0] record_id,
  output logic [15:0] content_length,
  output logic        record_valid,
  output logic        record_end,
  output logic [2:0]  end_action,
  output logic [15:0] begin_role,
  output logic        keep_connection
);

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;

  // record state carried between bytes
  fcrd_pkg::rec_state_t state;
  fcrd_pkg::rec_state_t state_next;

  // result register
  fcrd_pkg::byte_result_t res_next;
  fcrd_pkg::byte_result_t res;

  logic res_free;
  logic advance;
  logic accept;

  // result register can take a new byte when empty or being drained
  assign res_free = !out_valid || !out_stall;
  assign advance  = in_q_valid && res_free;
  assign in_stall = in_q_valid && !res_free;
  assign accept   = in_valid && !in_stall;

  fcrd_step u_step (
    .state_q    (state),
    .rx_byte    (in_q_byte),
    .state_next (state_next),
    .res        (res_next)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_byte <= rx_byte;
    end
  end

  // record state only moves when a byte is actually processed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign data_byte       = res.data_byte;
  assign byte_role       = res.byte_role;
  assign route           = res.route;
  assign header_done     = res.header_done;
  assign record_type     = res.record_type;
  assign record_id       = res.record_id;
  assign content_length  = res.content_length;
  assign record_valid    = res.record_valid;
  assign record_end      = res.record_end;
  assign end_action      = res.end_action;
  assign begin_role      = res.begin_role;
  assign keep_connection = res.keep_connection;

endmodule

// ===== rtl/core/fcrd_checker.sv =====
// ----------------------------------------------------------------------------
// fcrd_checker
// Port-level checks for the FastCGI record deframer, bound to the top level.
// ----------------------------------------------------------------------------
module fcrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  data_byte,
  input logic [1:0]  byte_role,
  input logic [2:0]  route,
  input logic        header_done,
  input logic        record_valid,
  input logic        record_end,
  input logic [2:0]  end_action,
  input logic [15:0] begin_role,
  input logic        keep_connection
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(end_action))
    else $error("stalled result changed");

  // action code only on the last byte of a record
  a_action_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_end |-> end_action == fcrd_pkg::ActNone)
    else $error("end action outside record end");

  // header and padding bytes never reach a stream
  a_no_route_off_content: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role != fcrd_pkg::RoleContent |-> route == fcrd_pkg::RouteDiscard)
    else $error("non-content byte routed");

  // validity is unknown before the header is complete
  a_valid_after_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == fcrd_pkg::RoleHeader && !header_done |-> !record_valid)
    else $error("record valid before header done");

  // begin values appear only with a begin action
  a_begin_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_action != fcrd_pkg::ActBegin |-> begin_role == 16'd0 && !keep_connection)
    else $error("begin fields outside begin action");

endmodule

bind fastcgi_record_deframer fcrd_checker u_fcrd_checker (.*);
